// ===== hdl/fcull_pkg.sv =====
// Shared constants for the frustum culler.
package fcull_pkg;

  localparam int NUM_PLANES          = 6;
  localparam int DEF_VALUE_WIDTH     = 32;
  localparam int DEF_FRAC_BITS       = 16;
  localparam int MIN_LEN_WIDTH       = 16;
  localparam logic [15:0] MIN_LEN_RESET = 16'd7;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_SPHERE = 2'd2,
    KIND_BOX    = 2'd3
  } kind_e;

endpackage

// ===== hdl/fcull_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module fcull_div #(
  parameter int N  = fcull_pkg::DEF_VALUE_WIDTH + fcull_pkg::DEF_FRAC_BITS,
  parameter int DW = fcull_pkg::DEF_VALUE_WIDTH + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [N-1:0]  dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [N-1:0]  quotient_o
);

  localparam int CW = $clog2(N + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q, div_q;
  logic [N-1:0]  quo_q;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_q, quo_q[N-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(trial - {1'b0, div_q}) : DW'(trial);
      quo_q <= {quo_q[N-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/frustum_culling_test_core.sv =====
// Six-plane frustum culler: plane store, renormalization and object tests.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  kind, column, ax..aw, bx..bz
//   out      output     out_valid_o / out_stall_i visible, load_done
//   cfg      input      cfg_valid_i / cfg_ready_o min_normal_length
//
// In a test, each plane reads its four coefficients from the normalized plane memory
// and shares one multiplier over the three normal terms. A load writes one raw
// coefficient per plane, then per plane sums the squared normal terms, takes the
// root and, above the minimum, divides the coefficients by it in the serial divider.
// Reset clears the per-entry valid bits of the raw memory and the filled flag of the
// normalized memory, so both read as zero until written. Input is stalled while an
// item is at work; a waiting result holds only the final step of the next item.
module frustum_culling_test_core #(
  parameter int VALUE_WIDTH = fcull_pkg::DEF_VALUE_WIDTH,
  parameter int FRAC_BITS   = fcull_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [1:0]                    column_i,
  input  logic signed [VALUE_WIDTH-1:0] ax_i,
  input  logic signed [VALUE_WIDTH-1:0] ay_i,
  input  logic signed [VALUE_WIDTH-1:0] az_i,
  input  logic signed [VALUE_WIDTH-1:0] aw_i,
  input  logic signed [VALUE_WIDTH-1:0] bx_i,
  input  logic signed [VALUE_WIDTH-1:0] by_i,
  input  logic signed [VALUE_WIDTH-1:0] bz_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          visible_o,
  output logic                          load_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fcull_pkg::MIN_LEN_WIDTH-1:0] cfg_data_i
);

  localparam int W    = VALUE_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int S    = 2 * W + 2;
  localparam int LW   = W + 1;
  localparam int QW   = W + F;
  localparam int PRW  = 2 * W;
  localparam int DSW  = W + 2;
  localparam int DEPTH = fcull_pkg::NUM_PLANES * 4;
  localparam logic [2:0] LAST_PLANE = 3'(fcull_pkg::NUM_PLANES - 1);
  localparam logic [QW-1:0]  VCAP_Q = QW'(1) << (W - 1);
  localparam logic [PRW-1:0] VCAP_P = PRW'(1) << (W - 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LDW  = 4'd1;
  localparam logic [3:0] ST_NRA  = 4'd2;
  localparam logic [3:0] ST_NMU  = 4'd3;
  localparam logic [3:0] ST_NAC  = 4'd4;
  localparam logic [3:0] ST_SQ   = 4'd5;
  localparam logic [3:0] ST_DRA  = 4'd6;
  localparam logic [3:0] ST_DLD  = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_TRA  = 4'd9;
  localparam logic [3:0] ST_TMU  = 4'd10;
  localparam logic [3:0] ST_TAC  = 4'd11;
  localparam logic [3:0] ST_TCMP = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  function automatic logic signed [W-1:0] with_sign(input logic [W-1:0] m, input logic neg);
    logic signed [W-1:0] r;
    if (neg)           r = W'(-m);
    else if (m[W-1])   r = VMAX;
    else               r = W'(m);
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat1(input logic signed [W:0] v);
    logic signed [W-1:0] r;
    if (v[W] != v[W-1]) r = v[W] ? VMIN : VMAX;
    else                r = v[W-1:0];
    return r;
  endfunction

  logic [3:0]  state_q, state_d;
  logic [2:0]  p_q;
  logic [1:0]  k_q;
  logic [4:0]  addr;
  logic [1:0]  kind_q, col_q;
  logic signed [W-1:0] ax_q, ay_q, az_q, aw_q, bx_q, by_q, bz_q;
  logic [fcull_pkg::MIN_LEN_WIDTH-1:0] min_len_q;
  logic        out_valid_q, visible_q, load_done_q, vis_q;

  // Plane memories and their validity.
  logic signed [W-1:0] raw_mem [DEPTH];
  logic signed [W-1:0] norm_mem [DEPTH];
  logic [DEPTH-1:0]    raw_vld_q;
  logic                norm_vld_q, raw_rv_q;
  logic signed [W-1:0] raw_rd_q, norm_rd_q, raw_rdv, norm_rdv;
  logic                raw_we, norm_we;
  logic signed [W-1:0] raw_wdata, norm_wdata;

  logic [PRW-1:0] prod_q;
  logic           pneg_q;
  logic [S-1:0]   sum_q, sq_rem_q, sq_res_q, sq_bit_q;
  logic [LW-1:0]  len_q;
  logic           dsign_q;
  logic signed [DSW-1:0] dist_q;

  logic           div_start, div_done;
  logic [QW-1:0]  div_q;

  logic signed [W-1:0] row_v, coord;
  logic [PRW-1:0]      pm;
  logic signed [W-1:0] term;
  logic [QW-1:0]       qcap;
  logic signed [DSW-1:0] thr;
  logic [S-1:0]        sq_try;
  logic                accept, out_free, last_k, last_p;

  // A load writes the request's column of every plane.
  assign addr      = (state_q == ST_LDW) ? {p_q, col_q} : {p_q, k_q};
  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign raw_rdv   = raw_rv_q ? raw_rd_q : '0;
  assign norm_rdv  = norm_vld_q ? norm_rd_q : '0;
  assign last_k    = (k_q == 2'd3);
  assign last_p    = (p_q == LAST_PLANE);

  always_comb begin
    case (p_q[2:1])
      2'd0:    row_v = ax_q;
      2'd1:    row_v = ay_q;
      default: row_v = az_q;
    endcase
  end
  assign raw_wdata = sat1(p_q[0] ? ({aw_q[W-1], aw_q} - {row_v[W-1], row_v})
                                 : ({aw_q[W-1], aw_q} + {row_v[W-1], row_v}));

  // Box tests take the max corner where the normal component is not negative.
  always_comb begin
    logic use_b;
    use_b = (kind_q == fcull_pkg::KIND_BOX) && !norm_rdv[W-1];
    case (k_q)
      2'd0:    coord = use_b ? bx_q : ax_q;
      2'd1:    coord = use_b ? by_q : ay_q;
      default: coord = use_b ? bz_q : az_q;
    endcase
  end

  assign pm   = (prod_q >> F) > VCAP_P ? VCAP_P : (prod_q >> F);
  assign term = with_sign(pm[W-1:0], pneg_q);
  assign qcap = (div_q > VCAP_Q) ? VCAP_Q : div_q;
  assign thr  = (kind_q == fcull_pkg::KIND_SPHERE) ? -{{2{aw_q[W-1]}}, aw_q} : '0;
  assign sq_try = sq_res_q + sq_bit_q;

  always_comb begin
    state_d    = state_q;
    raw_we     = 1'b0;
    norm_we    = 1'b0;
    norm_wdata = raw_rdv;
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: if (accept) state_d = (kind_i == fcull_pkg::KIND_LOAD) ? ST_LDW : ST_TRA;
      ST_LDW: begin
        raw_we = 1'b1;
        if (last_p) state_d = ST_NRA;
      end
      ST_NRA:  state_d = ST_NMU;
      ST_NMU:  state_d = ST_NAC;
      ST_NAC:  state_d = (k_q == 2'd2) ? ST_SQ : ST_NRA;
      ST_SQ:   if (sq_bit_q == '0) state_d = ST_DRA;
      ST_DRA:  state_d = ST_DLD;
      ST_DLD: begin
        if (len_q > LW'(min_len_q)) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          norm_we = 1'b1;
          state_d = last_k ? (last_p ? ST_DONE : ST_NRA) : ST_DRA;
        end
      end
      ST_DIV: begin
        norm_wdata = with_sign(qcap[W-1:0], dsign_q);
        if (div_done) begin
          norm_we = 1'b1;
          state_d = last_k ? (last_p ? ST_DONE : ST_NRA) : ST_DRA;
        end
      end
      ST_TRA:  state_d = ST_TMU;
      ST_TMU:  state_d = last_k ? ST_TCMP : ST_TAC;
      ST_TAC:  state_d = ST_TRA;
      ST_TCMP: state_d = last_p ? ST_DONE : ST_TRA;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (raw_we) raw_mem[addr] <= raw_wdata;
    raw_rd_q <= raw_mem[addr];
    if (norm_we) norm_mem[addr] <= norm_wdata;
    norm_rd_q <= norm_mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_q         <= '0;
      k_q         <= '0;
      raw_vld_q   <= '0;
      raw_rv_q    <= 1'b0;
      norm_vld_q  <= 1'b0;
      min_len_q   <= fcull_pkg::MIN_LEN_RESET;
      out_valid_q <= 1'b0;
      vis_q       <= 1'b1;
    end else begin
      state_q  <= state_d;
      raw_rv_q <= raw_vld_q[addr];
      if (cfg_valid_i) min_len_q <= cfg_data_i;
      if (raw_we) raw_vld_q[addr] <= 1'b1;
      if ((state_q == ST_DONE) && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)                out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          p_q   <= '0;
          k_q   <= '0;
          vis_q <= 1'b1;
        end
        ST_LDW: p_q <= last_p ? 3'd0 : p_q + 3'd1;
        ST_NAC: k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        ST_DLD, ST_DIV: begin
          if (norm_we) begin
            k_q <= k_q + 2'd1;
            if (last_k) begin
              p_q <= p_q + 3'd1;
              if (last_p) norm_vld_q <= 1'b1;
            end
          end
        end
        ST_TAC: k_q <= k_q + 2'd1;
        ST_TCMP: begin
          k_q <= '0;
          p_q <= p_q + 3'd1;
          if (dist_q < thr) vis_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      col_q  <= column_i;
      ax_q <= ax_i; ay_q <= ay_i; az_q <= az_i; aw_q <= aw_i;
      bx_q <= bx_i; by_q <= by_i; bz_q <= bz_i;
      dist_q <= '0;
      sum_q  <= '0;
    end
    case (state_q)
      ST_NMU: prod_q <= PRW'(mag(raw_rdv)) * PRW'(mag(raw_rdv));
      ST_NAC: begin
        if (k_q == 2'd2) begin
          sq_rem_q <= sum_q + S'(prod_q);
          sq_res_q <= '0;
          sq_bit_q <= S'(1) << (S - 2);
        end else begin
          sum_q <= sum_q + S'(prod_q);
        end
      end
      ST_SQ: begin
        if (sq_bit_q == '0) begin
          len_q <= sq_res_q[LW-1:0];
        end else begin
          if (sq_rem_q >= sq_try) begin
            sq_rem_q <= sq_rem_q - sq_try;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
        end
      end
      ST_DLD: begin
        dsign_q <= raw_rdv[W-1];
        if (norm_we && last_k) sum_q <= '0;
      end
      ST_DIV: if (norm_we && last_k) sum_q <= '0;
      ST_TMU: begin
        if (last_k) begin
          dist_q <= dist_q + {{2{norm_rdv[W-1]}}, norm_rdv};
        end else begin
          prod_q <= PRW'(mag(norm_rdv)) * PRW'(mag(coord));
          pneg_q <= norm_rdv[W-1] ^ coord[W-1];
        end
      end
      ST_TAC:  dist_q <= dist_q + {{2{term[W-1]}}, term};
      ST_TCMP: dist_q <= '0;
      ST_DONE: begin
        if (out_free) begin
          visible_q   <= (kind_q != fcull_pkg::KIND_LOAD) && vis_q;
          load_done_q <= (kind_q == fcull_pkg::KIND_LOAD);
        end
      end
      default: ;
    endcase
  end

  fcull_div #(
    .N  (QW),
    .DW (LW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag(raw_rdv), {F{1'b0}}}),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;
  assign load_done_o = load_done_q;

endmodule

// ===== tb/sv/frustum_culling_test_core_tb.sv =====
// Self-checking testbench for the six-plane frustum culler, with a built-in plane predictor.
`timescale 1ns / 1ps

module frustum_culling_test_core_tb;

  localparam int  W          = 32;
  localparam int  F          = 16;
  localparam int  LIMIT      = 6000000;
  localparam longint VMAX    = 64'sd2147483647;
  localparam longint VMIN    = -64'sd2147483648;
  localparam longint unsigned VCAP = 64'd2147483648;
  localparam logic signed [W-1:0] SMAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] SMIN = 32'sh80000000;
  localparam int  ONE        = 65536;

  typedef struct {
    fcull_pkg::kind_e     kind;
    logic [1:0]           column;
    logic signed [W-1:0]  ax, ay, az, aw, bx, by, bz;
  } cull_req_t;

  typedef struct {
    logic visible;
    logic load_done;
  } cull_res_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [1:0] kind_i, column_i;
  logic signed [W-1:0] ax_i, ay_i, az_i, aw_i, bx_i, by_i, bz_i;
  logic out_valid_o, out_stall_i, visible_o, load_done_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [15:0] cfg_data_i;

  cull_req_t req_q[$];
  cull_res_t verdict_q[$];
  cull_req_t cur_req;
  int err_cnt;
  int send_idle_pct;
  int stall_pct;
  int unsigned cycle_cnt;

  // Predictor state: raw and normalized plane coefficients, plane*4 + coefficient.
  logic signed [W-1:0] raw_coef[24];
  logic signed [W-1:0] unit_coef[24];
  longint unsigned     min_len;

  frustum_culling_test_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .column_i   (column_i),
    .ax_i       (ax_i),
    .ay_i       (ay_i),
    .az_i       (az_i),
    .aw_i       (aw_i),
    .bx_i       (bx_i),
    .by_i       (by_i),
    .bz_i       (bz_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .visible_o  (visible_o),
    .load_done_o(load_done_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic signed [W-1:0] clamp_val(longint v);
    if (v > VMAX) return SMAX;
    if (v < VMIN) return SMIN;
    return v[W-1:0];
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic signed [W-1:0] apply_sign(longint unsigned m, bit neg);
    longint v;
    if (m > VCAP) m = VCAP;
    v = neg ? -longint'(m) : longint'(m);
    return clamp_val(v);
  endfunction

  function automatic logic signed [W-1:0] fixed_mul(logic signed [W-1:0] a,
                                                   logic signed [W-1:0] b);
    longint unsigned p;
    p = magnitude(a) * magnitude(b);
    return apply_sign(p >> F, (a < 0) != (b < 0));
  endfunction

  function automatic logic signed [W-1:0] fixed_div(logic signed [W-1:0] c,
                                                   longint unsigned len);
    longint unsigned m, q, r;
    m = magnitude(c);
    q = m / len;
    r = m % len;
    for (int i = 0; i < F; i++) begin
      if (q > VCAP) break;
      q = q << 1;
      r = r << 1;
      if (r >= len) begin
        r = r - len;
        q = q | 64'd1;
      end
    end
    return apply_sign(q, c < 0);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void renormalize_planes();
    longint unsigned sum, len, m;
    for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        m = magnitude(raw_coef[p*4+k]);
        sum = sum + m * m;
      end
      len = int_sqrt(sum);
      for (int k = 0; k < 4; k++)
        unit_coef[p*4+k] = (len > min_len) ? fixed_div(raw_coef[p*4+k], len)
                                           : raw_coef[p*4+k];
    end
  endfunction

  function automatic longint plane_dist(int p, logic signed [W-1:0] x,
                                        logic signed [W-1:0] y, logic signed [W-1:0] z);
    return longint'(fixed_mul(unit_coef[p*4], x)) + longint'(fixed_mul(unit_coef[p*4+1], y))
         + longint'(fixed_mul(unit_coef[p*4+2], z)) + longint'(unit_coef[p*4+3]);
  endfunction

  // Updates the plane store for a load and returns the culling verdict of a request.
  function automatic cull_res_t cull_predict(cull_req_t r);
    cull_res_t res;
    logic signed [W-1:0] a[4];
    logic signed [W-1:0] b[3];
    longint d, v;
    a[0] = r.ax; a[1] = r.ay; a[2] = r.az; a[3] = r.aw;
    b[0] = r.bx; b[1] = r.by; b[2] = r.bz;
    res.visible = 1'b1;
    res.load_done = 1'b0;
    if (r.kind == fcull_pkg::KIND_LOAD) begin
      for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
        v = (p % 2) ? longint'(a[3]) - longint'(a[p/2]) : longint'(a[3]) + longint'(a[p/2]);
        raw_coef[p*4 + r.column] = clamp_val(v);
      end
      renormalize_planes();
      res.visible = 1'b0;
      res.load_done = 1'b1;
      return res;
    end
    for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
      if (r.kind == fcull_pkg::KIND_BOX)
        d = plane_dist(p, unit_coef[p*4] >= 0 ? b[0] : a[0],
                          unit_coef[p*4+1] >= 0 ? b[1] : a[1],
                          unit_coef[p*4+2] >= 0 ? b[2] : a[2]);
      else
        d = plane_dist(p, a[0], a[1], a[2]);
      if (r.kind == fcull_pkg::KIND_SPHERE) begin
        if (d < -longint'(a[3])) res.visible = 1'b0;
      end else if (d < 0) begin
        res.visible = 1'b0;
      end
    end
    return res;
  endfunction

  // Request driver: a request stays on the bus unchanged while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        verdict_q.push_back(cull_predict(cur_req));
      if (!(in_valid_i && in_stall_o)) begin
        if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_q.pop_front();
          in_valid_i <= 1'b1;
          kind_i     <= cur_req.kind;
          column_i   <= cur_req.column;
          ax_i <= cur_req.ax; ay_i <= cur_req.ay; az_i <= cur_req.az; aw_i <= cur_req.aw;
          bx_i <= cur_req.bx; by_i <= cur_req.by; bz_i <= cur_req.bz;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk_i or negedge rst_ni) begin
    cull_res_t exp_res;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result visible=%0b load_done=%0b",
                   $time, visible_o, load_done_o);
          err_cnt++;
        end else begin
          exp_res = verdict_q.pop_front();
          if (visible_o !== exp_res.visible) begin
            $display("%0t: visible expected %0b actual %0b", $time, exp_res.visible, visible_o);
            err_cnt++;
          end
          if (load_done_o !== exp_res.load_done) begin
            $display("%0t: load_done expected %0b actual %0b",
                     $time, exp_res.load_done, load_done_o);
            err_cnt++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("frustum_culling_test_core_tb: done, errors");
      $finish;
    end
  end

  function automatic cull_req_t make_req(fcull_pkg::kind_e k, logic [1:0] col,
                                         logic signed [W-1:0] ax, logic signed [W-1:0] ay,
                                         logic signed [W-1:0] az, logic signed [W-1:0] aw,
                                         logic signed [W-1:0] bx, logic signed [W-1:0] by,
                                         logic signed [W-1:0] bz);
    cull_req_t r;
    r.kind = k; r.column = col;
    r.ax = ax; r.ay = ay; r.az = az; r.aw = aw;
    r.bx = bx; r.by = by; r.bz = bz;
    return r;
  endfunction

  // Small signed Q16.16 value of random scale, so plane lengths straddle the threshold.
  function automatic logic signed [W-1:0] small_val();
    int s;
    s = $urandom_range(18, 4);
    return $signed($urandom_range((1 << s), 0)) - $signed(1 << (s - 1));
  endfunction

  function automatic logic signed [W-1:0] coord_val();
    return $signed($urandom_range(16 * ONE, 0)) - $signed(8 * ONE);
  endfunction

  function automatic logic signed [W-1:0] any_val();
    return $signed($urandom());
  endfunction

  task automatic push_random(int count);
    int n;
    logic signed [W-1:0] lo, hi;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 70) begin
        // A plausible matrix followed by a burst of object tests.
        for (int c = 0; c < 4; c++) begin
          req_q.push_back(make_req(fcull_pkg::KIND_LOAD, c[1:0], small_val(), small_val(),
                                   small_val(), small_val(), any_val(), any_val(),
                                   any_val()));
          n++;
        end
        repeat ($urandom_range(12, 6)) begin
          lo = coord_val();
          hi = coord_val();
          req_q.push_back(make_req(fcull_pkg::kind_e'($urandom_range(3, 1)), 2'($urandom()),
                                   coord_val(), coord_val(), lo,
                                   $signed($urandom_range(5 * ONE, 0)) - $signed(ONE),
                                   coord_val(), coord_val(), hi));
          n++;
        end
      end else begin
        repeat ($urandom_range(6, 1)) begin
          req_q.push_back(make_req(fcull_pkg::kind_e'($urandom_range(3, 0)), 2'($urandom()),
                                   any_val(), any_val(), any_val(), any_val(),
                                   any_val(), any_val(), any_val()));
          n++;
        end
      end
    end
  endtask

  task automatic write_min_len(logic [15:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    min_len = v;
  endtask

  task automatic wait_drained();
    while (req_q.size() > 0 || in_valid_i || verdict_q.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] min_len_set[5];
    int send_set[5];
    int stall_set[5];
    min_len_set = '{16'd0, 16'hffff, 16'd7, 16'd1, 16'd40000};
    send_set    = '{0, 88, 0, 38, 0};
    stall_set   = '{0, 0, 88, 38, 0};
    err_cnt = 0;
    cycle_cnt = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    kind_i = fcull_pkg::KIND_LOAD; column_i = '0;
    ax_i = '0; ay_i = '0; az_i = '0; aw_i = '0; bx_i = '0; by_i = '0; bz_i = '0;
    for (int i = 0; i < 24; i++) begin
      raw_coef[i] = '0;
      unit_coef[i] = '0;
    end
    min_len = fcull_pkg::MIN_LEN_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: tests on empty planes, saturating loads, extreme objects.
    req_q.push_back(make_req(fcull_pkg::KIND_POINT, 2'd0, SMAX, SMIN, '0, '0, '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_SPHERE, 2'd1, SMIN, SMIN, SMIN, SMIN,
                             '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_BOX, 2'd2, SMAX, SMAX, SMAX, SMIN,
                             SMIN, SMIN, SMIN));
    req_q.push_back(make_req(fcull_pkg::KIND_LOAD, 2'd0, SMAX, SMIN, SMAX, SMAX, '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_LOAD, 2'd1, SMIN, SMAX, SMIN, SMIN, '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_LOAD, 2'd2, ONE, -ONE, ONE, 2 * ONE,
                             '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_LOAD, 2'd3, '0, '0, -ONE, ONE, '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_POINT, 2'd3, '0, '0, '0, '0, '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_POINT, 2'd0, SMAX, SMAX, SMAX, '0, '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_POINT, 2'd0, SMIN, SMIN, SMIN, '0, '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_SPHERE, 2'd0, ONE, ONE, ONE, -ONE, '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_SPHERE, 2'd0, SMAX, '0, SMIN, SMAX,
                             '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_BOX, 2'd0, ONE, ONE, ONE, '0,
                             -ONE, -ONE, -ONE));
    req_q.push_back(make_req(fcull_pkg::KIND_BOX, 2'd0, SMIN, SMIN, SMIN, '0,
                             SMAX, SMAX, SMAX));
    req_q.push_back(make_req(fcull_pkg::KIND_LOAD, 2'd0, 32'sd3, -32'sd2, 32'sd1, 32'sd5,
                             '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_LOAD, 2'd1, '0, '0, '0, '0, '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_POINT, 2'd0, ONE, -ONE, ONE, '0, '0, '0, '0));
    req_q.push_back(make_req(fcull_pkg::KIND_BOX, 2'd0, -ONE, -ONE, -ONE, '0,
                             ONE, ONE, ONE));
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = send_set[ph];
      stall_pct = stall_set[ph];
      write_min_len(ph == 2 ? 16'($urandom()) : min_len_set[ph]);
      @(negedge clk_i);
      push_random(225);
      wait_drained();
    end

    if (verdict_q.size() > 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("frustum_culling_test_core_tb: done, clean");
    end else begin
      $display("frustum_culling_test_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fcull_pkg.sv
hdl/fcull_div.sv
hdl/frustum_culling_test_core.sv
tb/sv/frustum_culling_test_core_tb.sv
